// File: rtl/gsa_pkg.sv
// Shared beat types and opcode/status codes for the generational slot allocator.
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int IDX_W = 10;
    localparam int GEN_W = 32;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] slot_index;
    } req_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0] slot_index_out;
        logic [GEN_W-1:0] generation;
        logic [1:0]       status;
    } rsp_beat_t;

endpackage

// File: rtl/generational_slot_allocator.sv
// Top level of the generational slot allocator: request sequencer around two RAMs.
//
//   channel | direction | payload              | handshake
//   --------+-----------+----------------------+----------------------
//   req     | in        | gsa_pkg::req_beat_t  | req_valid / req_ready
//   rsp     | out       | gsa_pkg::rsp_beat_t  | rsp_valid / rsp_ready
//
// A request passes from S_IDLE to S_COMMIT, through S_POP for an allocate that pops the free
// stack: the pop reads the stack RAM and then the slot RAM at the popped index.
// Slot RAM holds {live, generation}; entries below the high-water mark were written
// when the slot was created, so no clearing pass runs after reset.
// Reset clears the counters, sequencer and response valid; the RAMs are not cleared.
// A stalled response holds the sequencer in its commit state; no state is written
// until the response register can take the beat.
`timescale 1ns / 1ps

module generational_slot_allocator #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  gsa_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output gsa_pkg::rsp_beat_t rsp
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int MW = (CW > gsa_pkg::IDX_W) ? CW : gsa_pkg::IDX_W;
    localparam int SW = gsa_pkg::GEN_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_COMMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [1:0]                  op_reg, op_next;
    logic [gsa_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [IW-1:0]               pop_reg, pop_next;
    logic                        popped_reg, popped_next;
    logic [CW-1:0]               fc_reg, fc_next;
    logic [CW-1:0]               hw_reg, hw_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    gsa_pkg::rsp_beat_t          rsp_reg, rsp_next;

    logic                        slot_rd_en, slot_wr_en;
    logic [IW-1:0]               slot_rd_addr, slot_wr_addr;
    logic [SW-1:0]               slot_rd_data, slot_wr_data;
    logic                        stk_rd_en, stk_wr_en;
    logic [IW-1:0]               stk_rd_addr, stk_wr_addr;
    logic [IW-1:0]               stk_rd_data, stk_wr_data;

    logic                        accept, commit_go, in_range, live_rd;
    logic [MW-1:0]               idx_m, hw_m;
    logic [gsa_pkg::GEN_W-1:0]   gen_rd, gen_inc;

    gsa_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SW)) u_slot_ram (
        .clk     (clk),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data)
    );

    gsa_ram #(.DEPTH(SLOT_COUNT), .WIDTH(IW)) u_stack_ram (
        .clk     (clk),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign commit_go = (state_reg == S_COMMIT) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign idx_m    = MW'(idx_reg);
    assign hw_m     = MW'(hw_reg);
    assign in_range = idx_m < hw_m;
    assign live_rd  = slot_rd_data[SW-1];
    assign gen_rd   = slot_rd_data[gsa_pkg::GEN_W-1:0];
    assign gen_inc  = gen_rd + 32'd1;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        pop_next       = pop_reg;
        popped_next    = popped_reg;
        fc_next        = fc_reg;
        hw_next        = hw_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        slot_rd_en   = 1'b0;
        slot_rd_addr = IW'(MW'(req.slot_index));
        slot_wr_en   = 1'b0;
        slot_wr_addr = idx_m[IW-1:0];
        slot_wr_data = {1'b0, gen_inc};
        stk_rd_en    = 1'b0;
        stk_rd_addr  = IW'(fc_reg - CW'(1));
        stk_wr_en    = 1'b0;
        stk_wr_addr  = fc_reg[IW-1:0];
        stk_wr_data  = idx_m[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.opcode;
                    idx_next    = req.slot_index;
                    slot_rd_en  = 1'b1;
                    popped_next = (req.opcode == gsa_pkg::OP_ALLOC) && (fc_reg != '0);
                    if ((req.opcode == gsa_pkg::OP_ALLOC) && (fc_reg != '0))
                    begin
                        stk_rd_en  = 1'b1;
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_POP:
            begin
                // chase the popped index into the slot RAM
                slot_rd_en   = 1'b1;
                slot_rd_addr = stk_rd_data;
                pop_next     = stk_rd_data;
                state_next   = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_go)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.slot_index_out = idx_reg;
                    rsp_next.generation     = '0;
                    rsp_next.status         = gsa_pkg::ST_OK;
                    state_next              = S_IDLE;
                    case (op_reg)
                        gsa_pkg::OP_ALLOC:
                        begin
                            if (popped_reg)
                            begin
                                fc_next                 = fc_reg - CW'(1);
                                slot_wr_en              = 1'b1;
                                slot_wr_addr            = pop_reg;
                                slot_wr_data            = {1'b1, gen_rd};
                                rsp_next.slot_index_out = gsa_pkg::IDX_W'(pop_reg);
                                rsp_next.generation     = gen_rd;
                            end
                            else if (hw_reg < CW'(SLOT_COUNT))
                            begin
                                hw_next                 = hw_reg + CW'(1);
                                slot_wr_en              = 1'b1;
                                slot_wr_addr            = hw_reg[IW-1:0];
                                slot_wr_data            = {1'b1, {gsa_pkg::GEN_W{1'b0}}};
                                rsp_next.slot_index_out = gsa_pkg::IDX_W'(hw_reg);
                            end
                            else
                            begin
                                rsp_next.slot_index_out = '0;
                                rsp_next.status         = gsa_pkg::ST_FULL;
                            end
                        end
                        gsa_pkg::OP_FREE:
                        begin
                            if (in_range && live_rd)
                            begin
                                fc_next             = fc_reg + CW'(1);
                                slot_wr_en          = 1'b1;
                                stk_wr_en           = 1'b1;
                                rsp_next.generation = gen_inc;
                            end
                            else
                            begin
                                rsp_next.generation = in_range ? gen_rd : '0;
                                rsp_next.status     = gsa_pkg::ST_BAD;
                            end
                        end
                        gsa_pkg::OP_QUERY:
                        begin
                            rsp_next.generation = in_range ? gen_rd : '0;
                        end
                        default:
                        begin
                            rsp_next.status = gsa_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            idx_reg       <= '0;
            pop_reg       <= '0;
            popped_reg    <= 1'b0;
            fc_reg        <= '0;
            hw_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            pop_reg       <= pop_next;
            popped_reg    <= popped_next;
            fc_reg        <= fc_next;
            hw_reg        <= hw_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

// File: rtl/gsa_ram.sv
// Simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module gsa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data when no read is issued
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
